/* src/ldtww_pkg.sv */
`default_nettype none

package ldtww_pkg;

	// number of digit positions on the driver
	localparam int unsigned DIGIT_COUNT = 4;
	localparam int unsigned DIGIT_IDX_W = $clog2(DIGIT_COUNT);

	// request kinds carried by an input item
	localparam logic [2:0] KIND_TICK   = 3'd0;
	localparam logic [2:0] KIND_LOAD   = 3'd1;
	localparam logic [2:0] KIND_BRIGHT = 3'd2;
	localparam logic [2:0] KIND_CLEAR  = 3'd3;
	localparam logic [2:0] KIND_DOT    = 3'd4;

	// transfer kind latched for the running sequence
	localparam logic [1:0] REQ_NONE   = 2'd0;
	localparam logic [1:0] REQ_SEND   = 2'd1;
	localparam logic [1:0] REQ_BRIGHT = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_HALF_PERIOD = 2'd0;
	localparam logic [1:0] CFG_DATA_CMD    = 2'd1;
	localparam logic [1:0] CFG_ADDR_CMD    = 2'd2;

	// configuration reset values
	localparam logic [15:0] HALF_PERIOD_RST = 16'd100;
	localparam logic [7:0]  DATA_CMD_RST    = 8'h40;
	localparam logic [7:0]  ADDR_CMD_RST    = 8'hC0;

	// byte constants
	localparam logic [7:0] BRIGHT_BASE = 8'h88;
	localparam logic [7:0] DOT_BIT     = 8'h80;
	localparam logic [7:0] SEG_RST     = 8'hFF;
	localparam logic [7:0] MAX_LEVEL   = 8'd7;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] digit_zero;
		logic [7:0] digit_one;
		logic [7:0] digit_two;
		logic [7:0] digit_three;
		logic [7:0] level;
		logic       dot_on;
		logic       data_line_in;
	} in_item_t;

	typedef struct packed {
		logic clock_line;
		logic data_line_out;
		logic data_drive;
		logic busy_res;
		logic sequence_done;
	} out_item_t;

endpackage : ldtww_pkg

`default_nettype wire

/* src/led_driver_two_wire_writer_unit.sv */
// Two-wire LED driver write sequencer, one input item per clock tick of the line timing.
// The result item for an input item is registered and valid in the cycle after it is accepted.
// Throughput: one item per cycle; in_ready falls only while a result waits unread.
// Reset (arst_n low): idle, pins high and driven, segment store all 0xFF,
// half period 100, data write command 0x40, start address command 0xC0.
`default_nettype none

module led_driver_two_wire_writer_unit (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire ldtww_pkg::in_item_t  in_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output ldtww_pkg::out_item_t      out_data,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [1:0]           cfg_index,
	input  wire logic [15:0]          cfg_data
);
	import ldtww_pkg::*;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_START_HIGH,
		PH_START_LOW,
		PH_BIT_LOW,
		PH_BIT_HIGH,
		PH_ACK_LOW,
		PH_ACK_WAIT,
		PH_ACK_HIGH,
		PH_STOP_A,
		PH_STOP_B,
		PH_STOP_C
	} phase_t;

	// configuration
	logic [15:0] half_period_q;
	logic [7:0]  data_cmd_q;
	logic [7:0]  addr_cmd_q;

	// sequencer state
	phase_t      phase_q, nx_phase;
	logic [7:0]  seg_q [DIGIT_COUNT];
	logic [7:0]  nx_seg [DIGIT_COUNT];
	logic [7:0]  shift_q, nx_shift;
	logic [3:0]  bit_cnt_q, nx_bit_cnt;
	logic [2:0]  byte_cnt_q, nx_byte_cnt;
	logic [15:0] delay_q, nx_delay;
	logic [1:0]  req_q, nx_req;
	logic        clk_pin_q, nx_clk_pin;
	logic        dat_pin_q, nx_dat_pin;
	logic        drv_pin_q, nx_drv_pin;
	logic        nx_done;

	// result register
	logic        out_valid_q;
	out_item_t   out_data_q;

	logic        in_fire;
	logic        entered;
	logic [15:0] period_ticks;
	logic [15:0] dec_delay;
	logic [7:0]  clamped_level;
	logic [DIGIT_IDX_W-1:0] next_digit;
	logic [2:0]  byte_inc;

	assign in_ready  = !out_valid_q || out_ready;
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// zero half period behaves as one tick
	assign period_ticks  = (half_period_q == 16'd0) ? 16'd1 : half_period_q;
	assign dec_delay     = (delay_q != 16'd0) ? delay_q - 16'd1 : 16'd0;
	assign clamped_level = (in_data.level > MAX_LEVEL) ? MAX_LEVEL : in_data.level;
	assign byte_inc      = byte_cnt_q + 3'd1;
	// store slot for the byte numbered byte_inc: (byte_inc - 2) mod 4
	assign next_digit    = DIGIT_IDX_W'(byte_cnt_q - 3'd1);

	// next state for one tick
	always_comb begin
		nx_phase    = phase_q;
		nx_seg      = seg_q;
		nx_shift    = shift_q;
		nx_bit_cnt  = bit_cnt_q;
		nx_byte_cnt = byte_cnt_q;
		nx_delay    = delay_q;
		nx_req      = req_q;
		nx_clk_pin  = clk_pin_q;
		nx_dat_pin  = dat_pin_q;
		nx_drv_pin  = drv_pin_q;
		nx_done     = 1'b0;
		entered     = 1'b0;

		if (phase_q == PH_IDLE) begin
			unique case (in_data.kind)
				KIND_LOAD, KIND_CLEAR: begin
					if (in_data.kind == KIND_LOAD) begin
						nx_seg[0] = in_data.digit_zero;
						nx_seg[1] = in_data.digit_one;
						nx_seg[2] = in_data.digit_two;
						nx_seg[3] = in_data.digit_three;
					end else begin
						for (int i = 0; i < DIGIT_COUNT; i++) nx_seg[i] = 8'h00;
					end
					nx_req      = REQ_SEND;
					nx_byte_cnt = 3'd0;
					nx_bit_cnt  = 4'd0;
					nx_shift    = data_cmd_q;
					nx_phase    = PH_START_HIGH;
					entered     = 1'b1;
				end
				KIND_BRIGHT: begin
					nx_req      = REQ_BRIGHT;
					nx_byte_cnt = 3'd0;
					nx_bit_cnt  = 4'd0;
					nx_shift    = BRIGHT_BASE + clamped_level;
					nx_phase    = PH_START_HIGH;
					entered     = 1'b1;
				end
				KIND_DOT: begin
					if (in_data.dot_on) nx_seg[1] = seg_q[1] + DOT_BIT;
				end
				default: begin
					// plain tick or unknown kind: nothing to do
				end
			endcase
		end else if (phase_q == PH_ACK_WAIT) begin
			// receiver acknowledges by pulling data low
			if (!in_data.data_line_in) begin
				nx_phase = PH_ACK_HIGH;
				entered  = 1'b1;
			end
		end else begin
			nx_delay = dec_delay;
			if (dec_delay == 16'd0) begin
				entered = 1'b1;
				unique case (phase_q)
					PH_START_HIGH: nx_phase = PH_START_LOW;
					PH_START_LOW: begin
						nx_bit_cnt = 4'd0;
						nx_phase   = PH_BIT_LOW;
					end
					PH_BIT_LOW:    nx_phase = PH_BIT_HIGH;
					PH_BIT_HIGH: begin
						nx_shift = {1'b0, shift_q[7:1]};
						if ((bit_cnt_q + 4'd1) >= 4'd8) begin
							nx_bit_cnt = 4'd0;
							nx_phase   = PH_ACK_LOW;
						end else begin
							nx_bit_cnt = bit_cnt_q + 4'd1;
							nx_phase   = PH_BIT_LOW;
						end
					end
					PH_ACK_LOW:    nx_phase = PH_ACK_WAIT;
					PH_ACK_HIGH: begin
						// segment bytes follow the address command
						if (req_q == REQ_SEND && byte_cnt_q >= 3'd1 && byte_cnt_q < 3'd5) begin
							nx_byte_cnt = byte_inc;
							nx_shift    = seg_q[next_digit];
							nx_bit_cnt  = 4'd0;
							nx_phase    = PH_BIT_LOW;
						end else begin
							nx_phase = PH_STOP_A;
						end
					end
					PH_STOP_A:     nx_phase = PH_STOP_B;
					PH_STOP_B:     nx_phase = PH_STOP_C;
					PH_STOP_C: begin
						if (req_q == REQ_SEND && byte_cnt_q == 3'd0) begin
							// second frame: address command and digits
							nx_byte_cnt = 3'd1;
							nx_shift    = addr_cmd_q;
							nx_bit_cnt  = 4'd0;
							nx_phase    = PH_START_HIGH;
						end else begin
							entered    = 1'b0;
							nx_phase   = PH_IDLE;
							nx_req     = REQ_NONE;
							nx_delay   = 16'd0;
							nx_clk_pin = 1'b1;
							nx_dat_pin = 1'b1;
							nx_drv_pin = 1'b1;
							nx_done    = 1'b1;
						end
					end
					default: begin
						entered  = 1'b0;
						nx_phase = PH_IDLE;
					end
				endcase
			end
		end

		// pin levels and delay on entry to a phase
		if (entered) begin
			nx_delay = (nx_phase == PH_START_LOW) ? 16'd1 : period_ticks;
			unique case (nx_phase)
				PH_START_HIGH: begin
					nx_clk_pin = 1'b1;
					nx_dat_pin = 1'b1;
					nx_drv_pin = 1'b1;
				end
				PH_START_LOW:  nx_dat_pin = 1'b0;
				PH_BIT_LOW: begin
					nx_clk_pin = 1'b0;
					nx_dat_pin = nx_shift[0];
				end
				PH_BIT_HIGH:   nx_clk_pin = 1'b1;
				PH_ACK_LOW:    nx_clk_pin = 1'b0;
				PH_ACK_WAIT:   nx_drv_pin = 1'b0;
				PH_ACK_HIGH: begin
					nx_drv_pin = 1'b1;
					nx_clk_pin = 1'b1;
				end
				PH_STOP_A:     nx_clk_pin = 1'b0;
				PH_STOP_B:     nx_dat_pin = 1'b0;
				PH_STOP_C:     nx_clk_pin = 1'b1;
				default: begin
				end
			endcase
		end
	end

	// state, configuration and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= HALF_PERIOD_RST;
			data_cmd_q    <= DATA_CMD_RST;
			addr_cmd_q    <= ADDR_CMD_RST;
			phase_q       <= PH_IDLE;
			for (int i = 0; i < DIGIT_COUNT; i++) seg_q[i] <= SEG_RST;
			shift_q       <= 8'h00;
			bit_cnt_q     <= 4'd0;
			byte_cnt_q    <= 3'd0;
			delay_q       <= 16'd0;
			req_q         <= REQ_NONE;
			clk_pin_q     <= 1'b1;
			dat_pin_q     <= 1'b1;
			drv_pin_q     <= 1'b1;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_HALF_PERIOD: half_period_q <= cfg_data;
					CFG_DATA_CMD:    data_cmd_q    <= cfg_data[7:0];
					CFG_ADDR_CMD:    addr_cmd_q    <= cfg_data[7:0];
					default: begin
					end
				endcase
			end
			if (in_fire) begin
				phase_q    <= nx_phase;
				seg_q      <= nx_seg;
				shift_q    <= nx_shift;
				bit_cnt_q  <= nx_bit_cnt;
				byte_cnt_q <= nx_byte_cnt;
				delay_q    <= nx_delay;
				req_q      <= nx_req;
				clk_pin_q  <= nx_clk_pin;
				dat_pin_q  <= nx_dat_pin;
				drv_pin_q  <= nx_drv_pin;
			end
			if (in_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (in_fire) begin
			out_data_q.clock_line    <= nx_clk_pin;
			out_data_q.data_line_out <= nx_dat_pin;
			out_data_q.data_drive    <= nx_drv_pin;
			out_data_q.busy_res      <= (nx_phase != PH_IDLE);
			out_data_q.sequence_done <= nx_done;
		end
	end

endmodule : led_driver_two_wire_writer_unit

`default_nettype wire
